// ===== sv/address_port_acl_matcher_unit_defines.svh =====
// ============================================================================
// Assertion macros for the address and port ACL matcher
// Shared property forms used by the checker that is bound to the top level.
// ============================================================================
`ifndef ADDRESS_PORT_ACL_MATCHER_UNIT_DEFINES_SVH
`define ADDRESS_PORT_ACL_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APAM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/apam_pkg.sv =====
// ============================================================================
// Address and port ACL matcher package
// Request codes, the stored rule layout and the address match functions.
// ============================================================================
package apam_pkg;

    // Request codes carried on the func field.
    typedef enum logic [1:0] {
        FN_CHECK  = 2'd0,
        FN_APPEND = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Upper 32 bits of the low half of an IPv4-mapped address.
    localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_ffff;
    localparam logic [7:0]  FULL_PREFIX   = 8'd128;

    // One stored allow rule.
    typedef struct packed {
        logic [63:0] net_upper;
        logic [63:0] net_lower;
        logic [7:0]  prefix;
        logic [15:0] port;
    } t_rule;

    // Maps an IPv4 address to ::ffff:a.b.c.d, passes IPv6 through.
    function automatic logic [127:0] canon_addr(
        input logic [63:0] hi,
        input logic [63:0] lo,
        input logic        is_v4
    );
        logic [127:0] res;
        if (is_v4) begin
            res = {64'd0, V4_MAPPED_TAG, lo[31:0]};
        end else begin
            res = {hi, lo};
        end
        return res;
    endfunction

    // True when addr lies in net/prefix. A prefix of zero matches all,
    // and a prefix above the full width never matches.
    function automatic logic prefix_hit(
        input logic [127:0] addr,
        input logic [127:0] net,
        input logic [7:0]   prefix
    );
        logic [127:0] mask;
        logic         hit;
        mask = ~({128{1'b1}} >> prefix);
        if (prefix > FULL_PREFIX) begin
            hit = 1'b0;
        end else begin
            hit = (((addr ^ net) & mask) == 128'd0);
        end
        return hit;
    endfunction

endpackage

// ===== sv/address_port_acl_matcher_unit.sv =====
// ============================================================================
// Address and port access control list matcher
// Keeps a table of CIDR allow rules with an optional port and answers
// whether a checked address and port is allowed by any stored rule.
// ============================================================================
//
//  Channel   Signals                                         Direction
//  --------  ----------------------------------------------  ---------
//  request   i_in_valid, o_in_stall, i_func, i_addr_high,    in
//            i_addr_low, i_addr_is_v4, i_prefix_len, i_port
//  result    o_out_valid, i_out_stall, o_allowed, o_status   out
//
//  Append, clear and unused requests load the output register at the
//  accepting edge. A check walks the rule RAM one entry per cycle, then
//  loads it from the done state once the output register is free.
//  Reset is synchronous and active low; it empties the table (count only).
//  A new request is taken while a result waits, unless that result is
//  stalled, in which case the request side stalls as well.
//
module address_port_acl_matcher_unit #(
    parameter int MAX_RULES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic        i_addr_is_v4,
    input  logic [7:0]  i_prefix_len,
    input  logic [15:0] i_port,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_allowed,
    output logic        o_status
);

    // Index width for the rule RAM and count width that can hold MAX_RULES.
    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int RW = $bits(apam_pkg::t_rule);

    // Sequencer state.
    apam_pkg::t_state r_state, n_state;

    // Rule count and scan bookkeeping.
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_rd_idx, n_rd_idx;
    logic           r_pend, n_pend;
    logic           r_hit, n_hit;

    // Canonical address and port of the check in flight.
    logic [127:0]   r_addr;
    logic [15:0]    r_port;

    // Output register.
    logic           r_out_vld, n_out_vld;
    logic           r_allowed, n_allowed;
    logic           r_status, n_status;

    // Control decoded from the state.
    logic           in_acc;
    logic           out_free;
    logic           table_full;
    logic           scan_more;
    logic           scan_end;
    logic           mem_re;
    logic           mem_we;
    logic           rule_match;
    logic [127:0]   in_addr;
    apam_pkg::t_func in_func;
    apam_pkg::t_rule wr_rule;
    apam_pkg::t_rule rd_rule;

    // The output register is free when it is empty or is being taken now.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_func    = apam_pkg::t_func'(i_func);
    assign in_addr    = apam_pkg::canon_addr(i_addr_high, i_addr_low, i_addr_is_v4);
    assign table_full = (r_count == CW'(MAX_RULES));

    // The scan issues one read per stored rule; the compare follows once the
    // registered read data comes back.
    assign scan_more  = (r_rd_idx != r_count);
    assign scan_end   = !scan_more && !r_pend;

    // An append writes the RAM only in the idle state and reads happen only
    // during a scan, so a write and a read of the same entry never overlap.
    assign wr_rule.net_upper = in_addr[127:64];
    assign wr_rule.net_lower = in_addr[63:0];
    assign wr_rule.prefix    = i_prefix_len;
    assign wr_rule.port      = i_port;

    apam_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_rule),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_rule)
    );

    // A rule with port zero admits any port; otherwise the ports must agree.
    assign rule_match = ((rd_rule.port == 16'd0) || (rd_rule.port == r_port)) &&
                        apam_pkg::prefix_hit(r_addr,
                                             {rd_rule.net_upper, rd_rule.net_lower},
                                             rd_rule.prefix);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apam_pkg::S_IDLE: begin
                if (in_acc && (in_func == apam_pkg::FN_CHECK)) begin
                    n_state = apam_pkg::S_SCAN;
                end
            end
            apam_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = apam_pkg::S_DONE;
                end
            end
            apam_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = apam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = apam_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs: request stall, RAM strobes, scan and result updates.
    always_comb begin
        o_in_stall = 1'b1;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_pend     = 1'b0;
        n_hit      = r_hit;
        n_out_vld  = r_out_vld && i_out_stall;
        n_allowed  = r_allowed;
        n_status   = r_status;
        unique case (r_state)
            apam_pkg::S_IDLE: begin
                o_in_stall = !out_free;
                n_rd_idx   = '0;
                n_hit      = 1'b0;
                if (in_acc) begin
                    // Every request gives a result; only a check waits for it.
                    n_allowed = 1'b0;
                    n_status  = 1'b0;
                    case (in_func)
                        apam_pkg::FN_CHECK: begin
                            n_out_vld = 1'b0;
                        end
                        apam_pkg::FN_APPEND: begin
                            n_out_vld = 1'b1;
                            if (table_full) begin
                                n_status = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        apam_pkg::FN_CLEAR: begin
                            n_out_vld = 1'b1;
                            n_count   = '0;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            apam_pkg::S_SCAN: begin
                if (scan_more) begin
                    mem_re   = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_pend   = 1'b1;
                end
                if (r_pend && rule_match) begin
                    n_hit = 1'b1;
                end
            end
            apam_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_allowed = r_hit;
                    n_status  = 1'b0;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= apam_pkg::S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_pend    <= n_pend;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_allowed <= n_allowed;
        r_status  <= n_status;
        if (in_acc) begin
            r_addr <= in_addr;
            r_port <= i_port;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_allowed   = r_allowed;
    assign o_status    = r_status;

endmodule

// ===== sv/apam_ram.sv =====
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ============================================================================
module apam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/apam_checker.sv =====
// ============================================================================
// Address and port ACL matcher checker
// Port-level assertions, bound to the top level.
// ============================================================================
`include "address_port_acl_matcher_unit_defines.svh"

module apam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_func,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_allowed,
    input logic        o_status
);

    logic in_acc;
    logic is_check;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_check = (i_func == apam_pkg::FN_CHECK);

    // A stalled result stays valid and keeps its value.
    `APAM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_allowed) && $stable(o_status),
        "stalled result changed")

    // Only an append can report a full table, and an append never allows.
    `APAM_ASSERT_NOW(a_excl, o_out_valid, !(o_allowed && o_status),
        "allowed and status both set")

    // Non-check requests finish at the next edge and never allow.
    `APAM_ASSERT_NEXT(a_fast, in_acc && !is_check, o_out_valid && !o_allowed,
        "non-check request result missing or allowed")

    // A check holds off further requests while it scans.
    `APAM_ASSERT_NEXT(a_scan_busy, in_acc && is_check, o_in_stall,
        "request taken during a scan")

endmodule

bind address_port_acl_matcher_unit apam_checker u_apam_checker (.*);

// ===== tb/sv/tb_apam_shadow_pkg.sv =====
// ============================================================================
// Shadow rule table for the address and port ACL matcher testbench
// Keeps its own copy of the allow rules, works out the verdict that each
// accepted request must produce, and checks returned verdicts in order.
// ============================================================================
package tb_apam_shadow_pkg;

    import apam_pkg::*;

    localparam int         RULE_SLOTS  = 64;
    // The fourth func code has no meaning; the block answers it with zeros.
    localparam logic [1:0] FN_RESERVED = 2'd3;

    typedef struct packed {
        logic allowed;
        logic status;
    } acl_verdict_t;

    class acl_shadow_table;
        logic [127:0] rule_net  [RULE_SLOTS];
        logic [7:0]   rule_len  [RULE_SLOTS];
        logic [15:0]  rule_port [RULE_SLOTS];
        int           rule_count;
        acl_verdict_t pending_verdicts [$];
        int           failures;

        function new();
            rule_count = 0;
            failures   = 0;
        endfunction

        // A zero length covers everything, a length past the address width
        // covers nothing.
        function bit rule_covers(int idx, logic [127:0] addr);
            logic [127:0] keep;
            if (rule_len[idx] == 8'd0) return 1'b1;
            if (rule_len[idx] > FULL_PREFIX) return 1'b0;
            keep = ~128'd0 << (128 - int'(rule_len[idx]));
            return ((addr ^ rule_net[idx]) & keep) == 128'd0;
        endfunction

        function void note_request(logic [1:0] fn, logic [63:0] hi, logic [63:0] lo,
                                   logic v4, logic [7:0] plen, logic [15:0] port);
            logic [127:0] addr;
            acl_verdict_t verdict;
            addr    = v4 ? {64'd0, V4_MAPPED_TAG, lo[31:0]} : {hi, lo};
            verdict = '0;
            case (fn)
                FN_CHECK: begin
                    for (int i = 0; i < rule_count; i++) begin
                        if ((rule_port[i] == 16'd0 || rule_port[i] == port) &&
                            rule_covers(i, addr)) begin
                            verdict.allowed = 1'b1;
                        end
                    end
                end
                FN_APPEND: begin
                    if (rule_count >= RULE_SLOTS) begin
                        verdict.status = 1'b1;
                    end else begin
                        rule_net[rule_count]  = addr;
                        rule_len[rule_count]  = plen;
                        rule_port[rule_count] = port;
                        rule_count++;
                    end
                end
                FN_CLEAR: begin
                    rule_count = 0;
                end
                default: begin
                end
            endcase
            pending_verdicts.push_back(verdict);
        endfunction

        function void check_verdict(realtime now, logic allowed, logic status);
            acl_verdict_t want;
            if (pending_verdicts.size() == 0) begin
                $display("%0.3f ns: result with no request outstanding: expected none, got allowed %0b status %0b",
                         now, allowed, status);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (allowed !== want.allowed) begin
                $display("%0.3f ns: allowed mismatch: expected %0b, got %0b",
                         now, want.allowed, allowed);
                failures++;
            end
            if (status !== want.status) begin
                $display("%0.3f ns: status mismatch: expected %0b, got %0b",
                         now, want.status, status);
                failures++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_address_port_acl_matcher_unit.sv =====
// ============================================================================
// Testbench for the address and port ACL matcher
// Drives rule appends, clears and address checks through the request channel
// under several idle and stall patterns and compares every verdict with a
// shadow rule table kept alongside the block.
// ============================================================================
module tb_address_port_acl_matcher_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import apam_pkg::*;
    import tb_apam_shadow_pkg::*;

    // Requests in the random part, spread evenly over the four phases.
    localparam int           RANDOM_REQUESTS = 1880;
    localparam logic [127:0] ALL_ONES        = {128{1'b1}};

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func       = FN_CHECK;
    logic [63:0] i_addr_high  = 64'd0;
    logic [63:0] i_addr_low   = 64'd0;
    logic        i_addr_is_v4 = 1'b0;
    logic [7:0]  i_prefix_len = 8'd0;
    logic [15:0] i_port       = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic        o_allowed;
    logic        o_status;

    // Chance, in percent per cycle, that the sender idles or the receiver
    // stalls. The main sequence changes these from phase to phase.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    // Requests sent so far, not counting the reserved func code.
    int requests_sent      = 0;

    acl_shadow_table shadow;

    address_port_acl_matcher_unit #(
        .MAX_RULES(RULE_SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_addr_high  (i_addr_high),
        .i_addr_low   (i_addr_low),
        .i_addr_is_v4 (i_addr_is_v4),
        .i_prefix_len (i_prefix_len),
        .i_port       (i_port),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_allowed    (o_allowed),
        .o_status     (o_status)
    );

    // A 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver decides at each falling edge whether to stall the next
    // rising edge. With a zero rate it never stalls.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Both handshakes are observed at the rising edge, where every input was
    // settled at the falling edge before. A verdict is checked before the request
    // taken at the same edge is noted; the verdict can never belong to it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                shadow.check_verdict($realtime, o_allowed, o_status);
            end
            if (i_in_valid && !o_in_stall) begin
                shadow.note_request(i_func, i_addr_high, i_addr_low, i_addr_is_v4,
                                    i_prefix_len, i_port);
            end
        end
    end

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Presents one request at a falling edge, after any idle cycles the
    // current phase draws, and holds it until the block takes it.
    task automatic send_request(input logic [1:0] fn, input logic [127:0] addr,
                                input logic v4, input logic [7:0] plen,
                                input logic [15:0] port);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_addr_high  <= addr[127:64];
        i_addr_low   <= addr[63:0];
        i_addr_is_v4 <= v4;
        i_prefix_len <= plen;
        i_port       <= port;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (fn != FN_RESERVED) requests_sent++;
    endtask

    // Appends a random rule. Exact-address rules and IPv4 rules are favored
    // so that later checks have something concrete to hit, and a few rules
    // carry a prefix past 128 that must never match.
    task automatic add_rule();
        logic [127:0] net;
        logic [7:0]   plen;
        logic [15:0]  port;
        logic         v4;
        int           pick;
        net  = rand128();
        v4   = ($urandom_range(2) == 0);
        pick = $urandom_range(9);
        if (pick == 0) begin
            plen = 8'd0;
        end else if (pick <= 2) begin
            plen = FULL_PREFIX;
        end else if (pick == 3) begin
            plen = 8'($urandom_range(255, 129));
        end else if (v4) begin
            plen = 8'($urandom_range(128, 96));
        end else begin
            plen = 8'($urandom_range(127, 1));
        end
        case ($urandom_range(7))
            0, 1, 2, 3: port = 16'd0;
            4:          port = 16'd80;
            5:          port = 16'd443;
            default:    port = 16'($urandom);
        endcase
        send_request(FN_APPEND, net, v4, plen, port);
    endtask

    // Checks an address. Most probes are aimed inside a stored rule, with
    // random host bits, and some of those have one network bit flipped so
    // that they just miss. Port choice mixes the rule's port, zero and noise.
    task automatic issue_probe();
        logic [127:0] addr;
        logic [127:0] keep;
        logic [15:0]  port;
        logic [7:0]   plen;
        logic         v4;
        int           r;
        int           pos;
        addr = rand128();
        port = 16'($urandom);
        v4   = 1'b0;
        if (shadow.rule_count > 0 && $urandom_range(4) != 0) begin
            r    = $urandom_range(shadow.rule_count - 1);
            plen = shadow.rule_len[r];
            if (plen != 8'd0 && plen <= FULL_PREFIX) begin
                keep = ~128'd0 << (128 - int'(plen));
                addr = (shadow.rule_net[r] & keep) | (addr & ~keep);
                if ($urandom_range(4) == 0) begin
                    pos       = 127 - $urandom_range(int'(plen) - 1);
                    addr[pos] = ~addr[pos];
                end
            end
            case ($urandom_range(4))
                0: port = 16'd0;
                1: begin
                end
                default: begin
                    if (shadow.rule_port[r] != 16'd0) port = shadow.rule_port[r];
                end
            endcase
        end
        // A mapped address is often sent in its short IPv4 form. The bits the
        // block must ignore in that form are filled with noise.
        if (addr[127:32] == {64'd0, V4_MAPPED_TAG}) begin
            v4 = 1'($urandom_range(1));
        end else begin
            v4 = ($urandom_range(7) == 0);
        end
        if (v4) addr[127:32] = {$urandom, $urandom, $urandom};
        send_request(FN_CHECK, addr, v4, 8'($urandom), port);
    endtask

    // One sequence: usually a clear, a handful of appends and a run of
    // checks. A fill sequence appends past the table size so that the
    // overflow flag shows. Now and then the sequence is pure noise instead.
    task automatic run_sequence(input bit fill);
        int n_rules;
        if (!fill && $urandom_range(6) == 0) begin
            repeat ($urandom_range(6, 1)) begin
                send_request(2'($urandom_range(3)), rand128(), 1'($urandom),
                             8'($urandom), 16'($urandom));
            end
            return;
        end
        n_rules = fill ? RULE_SLOTS + $urandom_range(3, 1) : $urandom_range(10);
        if (fill || $urandom_range(9) < 7) begin
            send_request(FN_CLEAR, rand128(), 1'($urandom), 8'($urandom), 16'($urandom));
        end
        repeat (n_rules) add_rule();
        repeat ($urandom_range(16, 4)) issue_probe();
    endtask

    // Main sequence: reset, the directed requests, four random phases with
    // different idle and stall patterns, then the drain.
    initial begin
        int phase_goal;
        shadow = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // An empty table denies everything, and the reserved code does nothing.
        send_request(FN_CHECK, ALL_ONES, 1'b0, 8'hff, 16'hffff);
        send_request(FN_RESERVED, ALL_ONES, 1'b1, 8'hff, 16'hffff);
        // The all-hosts rule on any port lets even a zero port through.
        send_request(FN_APPEND, 128'd0, 1'b0, 8'd0, 16'd0);
        send_request(FN_CHECK, ALL_ONES, 1'b1, 8'd0, 16'd0);
        // After a clear the old entry is still in memory but must not match.
        send_request(FN_CLEAR, ALL_ONES, 1'b1, 8'hff, 16'hffff);
        send_request(FN_CHECK, 128'd0, 1'b0, 8'd0, 16'd1);
        // Exact address with a fixed port: a zero check port only matches
        // any-port rules, and a flipped bit at either end misses.
        send_request(FN_APPEND, ALL_ONES, 1'b0, FULL_PREFIX, 16'hffff);
        send_request(FN_CHECK, ALL_ONES, 1'b0, 8'd0, 16'hffff);
        send_request(FN_CHECK, ALL_ONES, 1'b0, 8'd0, 16'd0);
        send_request(FN_CHECK, ALL_ONES ^ 128'd1, 1'b0, 8'd0, 16'hffff);
        send_request(FN_CHECK, {1'b0, ALL_ONES[126:0]}, 1'b0, 8'd0, 16'hffff);
        // 10.0.0.0/8 written as an IPv4 rule, with noise in the ignored bits,
        // then checked in both the short and the mapped form.
        send_request(FN_APPEND, {64'hfeed_f00d_cafe_0001, 32'hdead_beef, 32'h0a00_0000},
                     1'b1, 8'd104, 16'd443);
        send_request(FN_CHECK, {64'h1234_5678_9abc_def0, 32'h5555_aaaa, 32'h0a01_0203},
                     1'b1, 8'd0, 16'd443);
        send_request(FN_CHECK, {64'd0, V4_MAPPED_TAG, 32'h0a01_0203}, 1'b0, 8'd0, 16'd443);
        send_request(FN_CHECK, {64'd0, 32'd0, 32'h0b00_0001}, 1'b1, 8'd0, 16'd443);
        send_request(FN_CHECK, {64'd0, 32'd0, 32'h0a01_0203}, 1'b1, 8'd0, 16'd444);
        // Prefixes past 128 are stored but never match, not even zero.
        send_request(FN_APPEND, 128'd0, 1'b0, 8'hff, 16'd0);
        send_request(FN_APPEND, 128'd0, 1'b0, 8'd129, 16'd0);
        send_request(FN_CHECK, 128'd0, 1'b0, 8'd0, 16'd7);
        // A one-bit prefix splits the address space in half.
        send_request(FN_APPEND, {1'b1, 127'd0}, 1'b0, 8'd1, 16'd0);
        send_request(FN_CHECK, {1'b1, 127'h1234_5678}, 1'b0, 8'd0, 16'd9);
        send_request(FN_CHECK, {1'b0, ALL_ONES[126:0]}, 1'b0, 8'd0, 16'd9);
        send_request(FN_CLEAR, 128'd0, 1'b0, 8'd0, 16'd0);

        // Phases: no idling, a mostly idle sender, a mostly stalling receiver,
        // and light idling on both sides. Each opens with a table fill.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 76;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 76;
                end
                default: begin
                    sender_idle_pct    = 9;
                    receiver_stall_pct = 9;
                end
            endcase
            phase_goal = requests_sent + RANDOM_REQUESTS / 4;
            run_sequence(1'b1);
            while (requests_sent < phase_goal) run_sequence(1'b0);
        end

        @(negedge i_clk);
        i_in_valid         <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        // Wait for every verdict, then for longer than the slowest check
        // takes, so that a stray extra result would still be seen.
        while (shadow.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (RULE_SLOTS + 8) @(posedge i_clk);

        if (shadow.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
